// ===== src/rsc_pkg.sv =====
package rsc_pkg;

  // Accumulator width default and register field widths
  localparam int ACC_BITS_DEF = 64;
  localparam int RADIX_W      = 6;
  localparam int CFG_IDX_W    = 2;

  // Register reset values
  localparam logic [RADIX_W-1:0] SRC_RADIX_RST = 6'd10;
  localparam logic [RADIX_W-1:0] TGT_RADIX_RST = 6'd16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RADIX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RADIX = 2'd1;

  // Marks a character with no digit meaning
  localparam logic [7:0] CHAR_NONE = 8'd255;

  // Input beat and result beat
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [6:0] digit_char;
    logic       last_digit;
  } out_item_t;

  // Divider status towards the sequencer
  typedef struct packed {
    logic done;
    logic quo_zero;
  } div_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_READ,
    ST_EMIT
  } rsc_state_t;

  // Digit value of an ASCII character, CHAR_NONE if it has none
  function automatic logic [7:0] char_value(input logic [7:0] c);
    logic [7:0] v;
    v = CHAR_NONE;
    if (c inside {[8'h30:8'h39]}) begin
      v = c - 8'h30;
    end else if (c inside {[8'h41:8'h5A]}) begin
      v = c - 8'h41 + 8'd10;
    end else if (c inside {[8'h61:8'h7A]}) begin
      v = c - 8'h61 + 8'd10;
    end
    return v;
  endfunction

  function automatic logic radix_ok(input logic [RADIX_W-1:0] r);
    return (r >= 6'd2) && (r <= 6'd36);
  endfunction

  // ASCII glyph of a digit, 0-9 then A-Z; codes past Z wrap round
  function automatic logic [6:0] digit_glyph(input logic [RADIX_W-1:0] d);
    logic [RADIX_W-1:0] e;
    logic [6:0]         g;
    e = (d >= 6'd36) ? d - 6'd36 : d;
    if (e < 6'd10) begin
      g = 7'h30 + {1'b0, e};
    end else begin
      g = 7'h41 + {1'b0, e} - 7'd10;
    end
    return g;
  endfunction

endpackage

// ===== src/rsc_divider.sv =====
module rsc_divider
  import rsc_pkg::*;
#(
  parameter int ACC_BITS = ACC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [ACC_BITS-1:0] dividend,
  input  logic [RADIX_W-1:0]  divisor,
  output logic [ACC_BITS-1:0] quotient,
  output logic [RADIX_W-1:0]  remainder,
  output div_stat_t           stat
);

  localparam int CNT_W = (ACC_BITS > 1) ? $clog2(ACC_BITS) : 1;
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(ACC_BITS - 1);

  logic                active;
  logic                done;
  logic [CNT_W-1:0]    cnt;
  logic [ACC_BITS-1:0] quo;
  logic [RADIX_W-1:0]  rem;
  logic [RADIX_W:0]    rem_sh;
  logic [RADIX_W:0]    diff;
  logic                fits;

  // One quotient bit per cycle, restoring
  assign rem_sh = {rem, quo[ACC_BITS-1]};
  assign diff   = rem_sh - {1'b0, divisor};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active <= 1'b1;
        cnt    <= CNT_TOP;
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Shift register holds dividend bits, then quotient bits
  always_ff @(posedge clk) begin
    if (go) begin
      quo <= dividend;
      rem <= '0;
    end else if (active) begin
      quo <= {quo[ACC_BITS-2:0], fits};
      rem <= fits ? diff[RADIX_W-1:0] : rem_sh[RADIX_W-1:0];
    end
  end

  assign quotient      = quo;
  assign remainder     = rem;
  assign stat.done     = done;
  assign stat.quo_zero = (quo == '0);

endmodule

// ===== src/rsc_digit_buf.sv =====
module rsc_digit_buf
  import rsc_pkg::*;
#(
  parameter int DEPTH = ACC_BITS_DEF,
  parameter int AW    = $clog2(ACC_BITS_DEF)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [RADIX_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [RADIX_W-1:0] rd_data
);

  logic [RADIX_W-1:0] mem [DEPTH];

  // Digits land least significant first
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/radix_string_converter_top.sv =====
// Channel  | Ports                               | Handshake
// ---------+-------------------------------------+----------------------------------
// input    | start, busy, item                   | beat taken when start & !busy
// config   | cfg_valid, cfg_ready, cfg_index,    | beat taken when valid & ready
//          | cfg_data                            |
// result   | result_valid, result                | one-cycle strobe, no back-pressure
//
// A character that does not end a string is absorbed and busy stays low.
// A final character starts conversion when the target radix is valid: the bit-serial divider
// yields each output digit, then the digits are read back from the buffer and emitted.
// Reset is synchronous on rst; it clears the sequencer and accumulator and resets the radices.
// Results come out as strobes; the receiver cannot stall them.
module radix_string_converter_top
  import rsc_pkg::*;
#(
  parameter int ACC_BITS = ACC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             item,
  output logic                 result_valid,
  output out_item_t            result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RADIX_W-1:0]   cfg_data
);

  localparam int AW = (ACC_BITS > 1) ? $clog2(ACC_BITS) : 1;
  localparam int CW = $clog2(ACC_BITS + 1);

  rsc_state_t          state, state_next;
  logic [ACC_BITS-1:0] acc;
  logic                invalid;
  logic [ACC_BITS-1:0] work;
  logic [CW-1:0]       count;
  logic [RADIX_W-1:0]  src_radix;
  logic [RADIX_W-1:0]  tgt_radix;

  logic                accept;
  logic [7:0]          ch_val;
  logic                ch_ok;
  logic [ACC_BITS-1:0] acc_new;

  logic                div_go;
  logic [ACC_BITS-1:0] div_quo;
  logic [RADIX_W-1:0]  div_rem;
  div_stat_t           div_stat;

  logic                buf_wr;
  logic                buf_rd;
  logic [RADIX_W-1:0]  buf_data;
  logic [CW-1:0]       count_dec;

  assign accept    = start && (state == ST_IDLE);
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign count_dec = count - 1'b1;

  // Horner step: acc * radix + digit, wrapping; acc is kept if the character is not a valid digit
  assign ch_val  = char_value(item.char_code);
  assign ch_ok   = radix_ok(src_radix) && (ch_val < {2'b00, src_radix});
  assign acc_new = ch_ok ? ACC_BITS'(acc * src_radix) + ACC_BITS'(ch_val) : acc;

  // Sequencer
  always_comb begin
    state_next   = state;
    div_go       = 1'b0;
    buf_wr       = 1'b0;
    buf_rd       = 1'b0;
    result_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && item.last_char && radix_ok(tgt_radix)) begin
          state_next = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        div_go     = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          buf_wr     = 1'b1;
          state_next = div_stat.quo_zero ? ST_READ : ST_DIV_GO;
        end
      end
      ST_READ: begin
        buf_rd     = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        result_valid = 1'b1;
        state_next   = (count == '0) ? ST_IDLE : ST_READ;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Accumulator, digit count and register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      invalid   <= 1'b0;
      count     <= '0;
      src_radix <= SRC_RADIX_RST;
      tgt_radix <= TGT_RADIX_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SOURCE_RADIX: src_radix <= cfg_data;
          CFG_TARGET_RADIX: tgt_radix <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        if (item.last_char) begin
          acc     <= '0;
          invalid <= 1'b0;
          count   <= '0;
        end else begin
          acc     <= acc_new;
          invalid <= invalid | !ch_ok;
        end
      end
      if (buf_wr) begin
        count <= count + 1'b1;
      end else if (buf_rd) begin
        count <= count_dec;
      end
    end
  end

  // Value being converted
  always_ff @(posedge clk) begin
    if (accept && item.last_char) begin
      work <= (invalid || !ch_ok) ? '0 : acc_new;
    end else if (buf_wr) begin
      work <= div_quo;
    end
  end

  rsc_divider #(
    .ACC_BITS (ACC_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .go        (div_go),
    .dividend  (work),
    .divisor   (tgt_radix),
    .quotient  (div_quo),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  rsc_digit_buf #(
    .DEPTH (ACC_BITS),
    .AW    (AW)
  ) u_buf (
    .clk     (clk),
    .wr_en   (buf_wr),
    .wr_addr (count[AW-1:0]),
    .wr_data (div_rem),
    .rd_en   (buf_rd),
    .rd_addr (count_dec[AW-1:0]),
    .rd_data (buf_data)
  );

  // Most significant digit first; the last one marked
  assign result.digit_char = digit_glyph(buf_data);
  assign result.last_digit = (count == '0);

endmodule
